@@ sv/lgs_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lgs_pkg: shared types and constants of the linear gradient shader
// Request and tile mode codes, configuration register indexes, the fixed
// point formats of the gradient parameter and of the blended channels.
// ----------------------------------------------------------------------------
package lgs_pkg;

  // Q16.16 one and width of a tiled parameter in [0, 1.0]
  localparam int unsigned ONE_Q16 = 65536;
  localparam int unsigned U_W     = 17;
  localparam int unsigned W_W     = 16;

  // Blended channel: byte units with 16 fraction bits
  localparam int unsigned CH_W    = 24;
  localparam int unsigned PREM_W  = 2 * CH_W;

  // Half of 255 * 2^32, rounding bias of the premultiply divide
  localparam logic [PREM_W-1:0] PREMUL_BIAS = PREM_W'(255) << 31;
  localparam logic [8:0]        BYTE_MAX    = 9'd255;
  localparam logic [15:0]       DIV_BASE    = 16'd255;
  localparam logic [CH_W-1:0]   ROUND_HALF  = CH_W'(32768);

  localparam logic [4:0] STOP_COUNT_MIN = 5'd2;
  localparam logic [4:0] STOP_COUNT_RST = 5'd2;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_X      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_Y      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_OFFSET = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TILE_MODE   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_STOP_COUNT  = 3'd4;

  typedef enum logic {
    MODE_LOAD  = 1'b0,
    MODE_SHADE = 1'b1
  } mode_e;

  typedef enum logic [1:0] {
    TILE_CLAMP  = 2'd0,
    TILE_REPEAT = 2'd1,
    TILE_MIRROR = 2'd2
  } tile_mode_e;

  // Request fields that travel down the front of the pipeline
  typedef struct packed {
    mode_e       mode;
    logic [3:0]  slot;
    logic [31:0] color;
  } item_t;

  // Mapping and tiling setup
  typedef struct packed {
    logic [31:0] coef_x;
    logic [31:0] coef_y;
    logic [31:0] coef_offset;
    tile_mode_e  tile_mode;
  } param_cfg_t;

endpackage
`default_nettype wire

@@ sv/linear_gradient_shader.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// linear_gradient_shader: multi-stop linear gradient, one pixel per clock
// Maps each pixel center to t, tiles it, looks up the two neighboring
// color stops and emits their premultiplied blend as ARGB.
//
//   channel   handshake                        payload
//   request   in_valid_i / in_stall_o          mode_i x_pos_i y_pos_i
//                                              stop_index_i stop_color_i
//   result    out_valid_o / out_stall_i        pixel_o
//   config    cfg_we_i (no wait)               cfg_index_i cfg_wdata_i
//
// One request per clock; a shade request goes through parameter, tiling,
// stop split, table read, blend, premultiply and pack, while a load request
// writes the stop table from stage 4 and gives no result. The depth is set
// by the two coefficient multipliers, the stop index multiplier, the table
// read and the premultiply divide. Reset clears valid bits and configuration;
// the stop table is undefined until loaded. While a pixel waits under
// out_stall_i the whole pipeline holds and in_stall_o is raised.
// ----------------------------------------------------------------------------
module linear_gradient_shader
  import lgs_pkg::*;
#(
  parameter int unsigned MAX_STOPS  = 16,
  parameter int unsigned COORD_BITS = 12
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // request
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [0:0]            mode_i,
  input  logic [COORD_BITS-1:0] x_pos_i,
  input  logic [COORD_BITS-1:0] y_pos_i,
  input  logic [3:0]            stop_index_i,
  input  logic [31:0]           stop_color_i,
  // result
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [31:0]           pixel_o,
  // configuration
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [31:0]           cfg_wdata_i
);

  localparam int unsigned IDX_W = (MAX_STOPS > 1) ? $clog2(MAX_STOPS) : 1;
  localparam int unsigned F_W   = U_W + IDX_W;

  param_cfg_t        cfg_q;
  logic [4:0]        stop_count_q;
  logic [IDX_W-1:0]  nm1;
  logic              en;
  item_t             item_in;

  logic              valid3;
  item_t             item3;
  logic [U_W-1:0]    u3;

  logic [F_W-1:0]    f;
  logic [IDX_W:0]    idx_raw;
  logic              at_end;
  logic [IDX_W-1:0]  idx0_d, idx1_d, idx0_q, idx1_q;
  logic [W_W-1:0]    w4_d, w4_q, w5_q;
  logic              valid4_q, valid5_q;
  item_t             item4_q;
  logic              slot_ok;
  logic              ram_we;
  logic [31:0]       s0, s1;

  // Pipeline advances unless a finished pixel is held off
  assign en         = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.coef_x      <= '0;
      cfg_q.coef_y      <= '0;
      cfg_q.coef_offset <= '0;
      cfg_q.tile_mode   <= TILE_CLAMP;
      stop_count_q      <= STOP_COUNT_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_COEF_X:      cfg_q.coef_x      <= cfg_wdata_i;
        CFG_COEF_Y:      cfg_q.coef_y      <= cfg_wdata_i;
        CFG_COEF_OFFSET: cfg_q.coef_offset <= cfg_wdata_i;
        CFG_TILE_MODE:   cfg_q.tile_mode   <= tile_mode_e'(cfg_wdata_i[1:0]);
        CFG_STOP_COUNT:  stop_count_q      <= cfg_wdata_i[4:0];
        default: ;
      endcase
    end
  end

  // Saturate stop count to [2, MAX_STOPS], keep n-1
  always_comb begin
    if (stop_count_q < STOP_COUNT_MIN) begin
      nm1 = IDX_W'(1);
    end else if (32'(stop_count_q) > MAX_STOPS) begin
      nm1 = IDX_W'(MAX_STOPS - 1);
    end else begin
      nm1 = IDX_W'(stop_count_q - 5'd1);
    end
  end

  assign item_in = '{mode: mode_e'(mode_i), slot: stop_index_i, color: stop_color_i};

  // Stages 1 to 3: parameter and tiling
  lgs_param #(
    .COORD_BITS(COORD_BITS)
  ) u_param (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .item_i  (item_in),
    .x_pos_i (x_pos_i),
    .y_pos_i (y_pos_i),
    .cfg_i   (cfg_q),
    .valid_o (valid3),
    .item_o  (item3),
    .u_o     (u3)
  );

  // Stage 4: scale by n-1, split into stop index and weight
  assign f       = F_W'(u3) * F_W'(nm1);
  assign idx_raw = f[F_W-1:W_W];
  assign at_end  = idx_raw >= {1'b0, nm1};
  assign idx0_d  = at_end ? nm1 : idx_raw[IDX_W-1:0];
  assign idx1_d  = at_end ? nm1 : idx_raw[IDX_W-1:0] + IDX_W'(1);
  assign w4_d    = at_end ? '0 : f[W_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid4_q <= 1'b0;
      valid5_q <= 1'b0;
    end else if (en) begin
      valid4_q <= valid3;
      valid5_q <= valid4_q && (item4_q.mode == MODE_SHADE);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      item4_q <= item3;
      idx0_q  <= idx0_d;
      idx1_q  <= idx1_d;
      w4_q    <= w4_d;
      w5_q    <= w4_q;
    end
  end

  // Load requests write both table copies; shade requests read them
  assign slot_ok = 32'(item4_q.slot) < MAX_STOPS;
  assign ram_we  = en && valid4_q && (item4_q.mode == MODE_LOAD) && slot_ok;

  lgs_ram #(
    .WIDTH(32),
    .DEPTH(MAX_STOPS)
  ) u_ram_lo (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (IDX_W'(item4_q.slot)),
    .wdata_i (item4_q.color),
    .re_i    (en),
    .raddr_i (idx0_q),
    .rdata_o (s0)
  );

  lgs_ram #(
    .WIDTH(32),
    .DEPTH(MAX_STOPS)
  ) u_ram_hi (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (IDX_W'(item4_q.slot)),
    .wdata_i (item4_q.color),
    .re_i    (en),
    .raddr_i (idx1_q),
    .rdata_o (s1)
  );

  // Stages 6 to 8: blend, premultiply, pack
  lgs_color u_color (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (valid5_q),
    .w_i     (w5_q),
    .s0_i    (s0),
    .s1_i    (s1),
    .valid_o (out_valid_o),
    .pixel_o (pixel_o)
  );

  // Stop pair stays inside the active stops and is adjacent or one stop
  a_stop_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid4_q && (item4_q.mode == MODE_SHADE)
      |-> (idx0_q <= nm1) && ((idx1_q == idx0_q) || (idx1_q == idx0_q + IDX_W'(1))))
    else $error("stop pair out of range");

  // Last stop is used alone
  a_last_stop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid4_q && (item4_q.mode == MODE_SHADE) && (idx0_q == nm1)
      |-> (w4_q == '0) && (idx1_q == idx0_q))
    else $error("blend past last stop");

  // A held pixel keeps the pipeline frozen for the next cycle too
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(valid5_q) && $stable(idx0_q))
    else $error("pipeline moved under stall");

endmodule
`default_nettype wire

@@ sv/lgs_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lgs_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; read data holds while the
// read enable is low. Contents are undefined until written.
// ----------------------------------------------------------------------------
module lgs_ram #(
  parameter  int unsigned WIDTH = 32,
  parameter  int unsigned DEPTH = 16,
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

@@ sv/lgs_param.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lgs_param: gradient parameter and tiling, pipeline stages 1 to 3
// Stage 1 multiplies the doubled pixel centers by the coefficients, stage 2
// sums and halves with floor to get t in Q16.16, stage 3 tiles t into
// [0, 1.0].
// ----------------------------------------------------------------------------
module lgs_param
  import lgs_pkg::*;
#(
  parameter int unsigned COORD_BITS = 12
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic                  valid_i,
  input  item_t                 item_i,
  input  logic [COORD_BITS-1:0] x_pos_i,
  input  logic [COORD_BITS-1:0] y_pos_i,
  input  param_cfg_t            cfg_i,
  output logic                  valid_o,
  output item_t                 item_o,
  output logic [U_W-1:0]        u_o
);

  localparam int unsigned MUL_W  = COORD_BITS + 2;
  localparam int unsigned PROD_W = 32 + MUL_W;
  localparam int unsigned ACC_W  = PROD_W + 2;
  localparam int unsigned T_W    = ACC_W - 1;

  logic                     valid1_q, valid2_q, valid3_q;
  item_t                    item1_q, item2_q, item3_q;
  logic signed [MUL_W-1:0]  x_odd, y_odd;
  logic signed [PROD_W-1:0] prod_x_d, prod_y_d, prod_x_q, prod_y_q;
  logic signed [ACC_W-1:0]  acc;
  logic        [T_W-1:0]    t_d, t_q;
  logic                     t_neg, t_over;
  logic        [U_W-1:0]    t_mod2;
  logic        [U_W-1:0]    u_d, u_q;

  // Stage 1: a*(2x+1) and b*(2y+1)
  assign x_odd    = $signed({1'b0, x_pos_i, 1'b1});
  assign y_odd    = $signed({1'b0, y_pos_i, 1'b1});
  assign prod_x_d = $signed(cfg_i.coef_x) * x_odd;
  assign prod_y_d = $signed(cfg_i.coef_y) * y_odd;

  // Stage 2: 2t = sum of products plus 2c, halve with floor
  assign acc = $signed({{2{prod_x_q[PROD_W-1]}}, prod_x_q})
             + $signed({{2{prod_y_q[PROD_W-1]}}, prod_y_q})
             + $signed({{(ACC_W-33){cfg_i.coef_offset[31]}}, cfg_i.coef_offset, 1'b0});
  assign t_d = acc[ACC_W-1:1];

  // Stage 3: bring t into [0, 1.0]
  assign t_neg  = t_q[T_W-1];
  assign t_over = $signed(t_q) > $signed(T_W'(ONE_Q16));
  assign t_mod2 = t_q[U_W-1:0];

  always_comb begin
    case (cfg_i.tile_mode)
      TILE_REPEAT: begin
        u_d = {1'b0, t_q[W_W-1:0]};
      end
      TILE_MIRROR: begin
        if (t_mod2 > U_W'(ONE_Q16)) begin
          u_d = U_W'(0) - t_mod2;
        end else begin
          u_d = t_mod2;
        end
      end
      default: begin
        if (t_neg) begin
          u_d = '0;
        end else if (t_over) begin
          u_d = U_W'(ONE_Q16);
        end else begin
          u_d = t_mod2;
        end
      end
    endcase
  end

  // Advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid1_q <= 1'b0;
      valid2_q <= 1'b0;
      valid3_q <= 1'b0;
    end else if (en_i) begin
      valid1_q <= valid_i;
      valid2_q <= valid1_q;
      valid3_q <= valid2_q;
    end
  end

  // Advance payload
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      item1_q  <= item_i;
      prod_x_q <= prod_x_d;
      prod_y_q <= prod_y_d;
      item2_q  <= item1_q;
      t_q      <= t_d;
      item3_q  <= item2_q;
      u_q      <= u_d;
    end
  end

  assign valid_o = valid3_q;
  assign item_o  = item3_q;
  assign u_o     = u_q;

  // Tiled parameter never exceeds 1.0
  a_u_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && (item_o.mode == MODE_SHADE) |-> u_o <= U_W'(ONE_Q16))
    else $error("tiled parameter above 1.0");

endmodule
`default_nettype wire

@@ sv/lgs_color.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lgs_color: stop blend, premultiply and pack, pipeline stages 6 to 8
// Stage 6 blends the two stops per channel, stage 7 rounds alpha and
// multiplies each color by alpha, stage 8 divides by 255 * 2^32 with
// rounding and holds the packed ARGB result.
// ----------------------------------------------------------------------------
module lgs_color
  import lgs_pkg::*;
(
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           valid_i,
  input  logic [W_W-1:0] w_i,
  input  logic [31:0]    s0_i,
  input  logic [31:0]    s1_i,
  output logic           valid_o,
  output logic [31:0]    pixel_o
);

  logic                valid6_q, valid7_q, valid8_q;
  logic [CH_W-1:0]     chan_d [4];
  logic [CH_W-1:0]     chan_q [4];
  logic [7:0]          alpha_d, alpha_q;
  logic [PREM_W-1:0]   prem_d [3];
  logic [PREM_W-1:0]   prem_q [3];
  logic [7:0]          byte_d [3];
  logic [31:0]         pixel_d, pixel_q;

  // Stage 6: c = c0*(1-w) + c1*w per channel, alpha first
  always_comb begin
    logic [U_W-1:0]  inv_w;
    logic [7:0]      a0, a1;
    logic [CH_W:0]   p0, p1;
    inv_w = U_W'(ONE_Q16) - {1'b0, w_i};
    for (int k = 0; k < 4; k++) begin
      a0        = s0_i[8*(3-k) +: 8];
      a1        = s1_i[8*(3-k) +: 8];
      p0        = (CH_W+1)'(a0) * (CH_W+1)'(inv_w);
      p1        = (CH_W+1)'(a1) * (CH_W+1)'(w_i);
      chan_d[k] = CH_W'(p0 + p1);
    end
  end

  // Stage 7: round alpha, multiply colors by blended alpha
  assign alpha_d = 8'((chan_q[0] + ROUND_HALF) >> 16);
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      prem_d[k] = PREM_W'(chan_q[k+1]) * PREM_W'(chan_q[0]);
    end
  end

  // Stage 8: round and divide by 255 * 2^32, then saturate to a byte
  always_comb begin
    logic [PREM_W-1:0] biased;
    logic [15:0]       hi;
    logic [7:0]        q0;
    logic [15:0]       rem;
    logic [8:0]        quo;
    for (int k = 0; k < 3; k++) begin
      biased = prem_q[k] + PREMUL_BIAS;
      hi     = biased[PREM_W-1:32];
      q0     = hi[15:8];
      rem    = hi - ({q0, 8'd0} - 16'(q0));
      quo    = (rem >= DIV_BASE) ? 9'(q0) + 9'd1 : 9'(q0);
      byte_d[k] = (quo > BYTE_MAX) ? BYTE_MAX[7:0] : quo[7:0];
    end
  end
  assign pixel_d = {alpha_q, byte_d[0], byte_d[1], byte_d[2]};

  // Advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid6_q <= 1'b0;
      valid7_q <= 1'b0;
      valid8_q <= 1'b0;
    end else if (en_i) begin
      valid6_q <= valid_i;
      valid7_q <= valid6_q;
      valid8_q <= valid7_q;
    end
  end

  // Advance payload
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      chan_q  <= chan_d;
      alpha_q <= alpha_d;
      prem_q  <= prem_d;
      pixel_q <= pixel_d;
    end
  end

  assign valid_o = valid8_q;
  assign pixel_o = pixel_q;

  // Premultiplied colors never exceed alpha
  a_premul: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (pixel_o[23:16] <= pixel_o[31:24]) && (pixel_o[15:8] <= pixel_o[31:24])
             && (pixel_o[7:0] <= pixel_o[31:24]))
    else $error("color channel above alpha");

endmodule
`default_nettype wire

@@ bench/lgs_pixel_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lgs_pixel_checker: pixel predictor and scoreboard for the gradient shader
// Watches the configuration port, the request and the result channel. It keeps its own
// copy of the gradient setup and the stop table, computes the expected pixel
// of every accepted shade request, and compares accepted pixels in order.
// ----------------------------------------------------------------------------
module lgs_pixel_checker
  import lgs_pkg::*;
#(
  parameter int unsigned MAX_STOPS  = 16,
  parameter int unsigned COORD_BITS = 12
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // request channel
  input  logic                  in_valid_i,
  input  logic                  req_stall_i,
  input  logic [0:0]            mode_i,
  input  logic [COORD_BITS-1:0] x_pos_i,
  input  logic [COORD_BITS-1:0] y_pos_i,
  input  logic [3:0]            stop_index_i,
  input  logic [31:0]           stop_color_i,
  // result channel
  input  logic                  out_valid_i,
  input  logic                  out_stall_i,
  input  logic [31:0]           pixel_i,
  // configuration port
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [31:0]           cfg_wdata_i,
  // status to the bench top
  output int                    pending_o,
  output int                    mismatch_cnt_o
);

  // Gradient setup as last written
  logic signed [31:0] grad_cx;
  logic signed [31:0] grad_cy;
  logic signed [31:0] grad_off;
  logic [1:0]         grad_tile;
  logic [4:0]         grad_stops;
  logic [31:0]        stop_colors [MAX_STOPS];

  // Pixels still owed by the block, oldest first
  logic [31:0]        pixels_due [$];
  logic [31:0]        want;

  // Premultiplied ARGB of the gradient at pixel center (px+0.5, py+0.5)
  function automatic logic [31:0] shade_pixel(input logic [COORD_BITS-1:0] px,
                                              input logic [COORD_BITS-1:0] py);
    longint            sum2;
    longint            t;
    longint unsigned   u, f, idx, w, i1, n, d, ch, a0, a1;
    longint unsigned   c [4];
    logic [31:0]       s0, s1, pix;
    logic [63:0]       alpha;
    int                k;
    n = (grad_stops < 2) ? 2 : ((grad_stops > MAX_STOPS) ? MAX_STOPS : grad_stops);

    // Twice the parameter is exact; halve with floor
    sum2 = longint'(grad_cx) * (2 * longint'(px) + 1)
         + longint'(grad_cy) * (2 * longint'(py) + 1)
         + 2 * longint'(grad_off);
    t = sum2 >>> 1;

    // Fold t into [0, 1.0]; the unused code behaves as clamp
    if (grad_tile == TILE_REPEAT) begin
      u = t & 64'hFFFF;
    end else if (grad_tile == TILE_MIRROR) begin
      u = t & 64'h1FFFF;
      if (u > ONE_Q16) u = 2 * ONE_Q16 - u;
    end else if (t < 0) begin
      u = 0;
    end else if (t > longint'(ONE_Q16)) begin
      u = ONE_Q16;
    end else begin
      u = t;
    end

    // Stop pair and blend weight; at the far end use the last stop alone
    f   = u * (n - 1);
    idx = f >> 16;
    w   = f & 64'hFFFF;
    if (idx >= n - 1) begin
      idx = n - 1;
      w   = 0;
    end
    i1 = (idx + 1 < n) ? idx + 1 : idx;
    s0 = stop_colors[idx];
    s1 = stop_colors[i1];

    for (k = 0; k < 4; k++) begin
      a0   = (s0 >> (24 - 8 * k)) & 8'hFF;
      a1   = (s1 >> (24 - 8 * k)) & 8'hFF;
      c[k] = a0 * (ONE_Q16 - w) + a1 * w;
    end

    // Round alpha, then premultiply each color channel with rounding
    alpha       = (c[0] + ONE_Q16 / 2) >> 16;
    pix         = '0;
    pix[31:24]  = alpha[7:0];
    d           = 64'd255 << 32;
    for (k = 1; k < 4; k++) begin
      ch = (c[k] * c[0] + d / 2) / d;
      if (ch > 255) ch = 255;
      pix[24 - 8 * k +: 8] = ch[7:0];
    end
    return pix;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grad_cx        = '0;
      grad_cy        = '0;
      grad_off       = '0;
      grad_tile      = TILE_CLAMP;
      grad_stops     = STOP_COUNT_RST;
      pixels_due.delete();
      pending_o      = 0;
      mismatch_cnt_o = 0;
    end else begin
      // Retire an accepted pixel against the oldest expectation
      if (out_valid_i && !out_stall_i) begin
        if (pixels_due.size() == 0) begin
          $display("%0t: unexpected pixel, expected none, actual %08h", $time, pixel_i);
          mismatch_cnt_o++;
        end else begin
          want = pixels_due.pop_front();
          if (pixel_i !== want) begin
            $display("%0t: pixel mismatch, expected %08h, actual %08h",
                     $time, want, pixel_i);
            mismatch_cnt_o++;
          end
        end
      end

      // Accept a request: shade queues a pixel, load updates the table
      if (in_valid_i && !req_stall_i) begin
        if (mode_i == MODE_SHADE) begin
          pixels_due = {pixels_due, shade_pixel(x_pos_i, y_pos_i)};
        end else if (stop_index_i < MAX_STOPS) begin
          stop_colors[stop_index_i] = stop_color_i;
        end
      end

      // Track register writes
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_COEF_X:      grad_cx    = cfg_wdata_i;
          CFG_COEF_Y:      grad_cy    = cfg_wdata_i;
          CFG_COEF_OFFSET: grad_off   = cfg_wdata_i;
          CFG_TILE_MODE:   grad_tile  = cfg_wdata_i[1:0];
          CFG_STOP_COUNT:  grad_stops = cfg_wdata_i[4:0];
          default: ;
        endcase
      end

      pending_o = pixels_due.size();
    end
  end

endmodule

@@ bench/linear_gradient_shader_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// linear_gradient_shader_tb: regression bench for the gradient shader
// Loads the stop table, walks directed corner cases (both ends of the
// gradient, every tile mode, saturated stop counts, extreme coefficients),
// then runs random phases of loads and shades under random request bursts
// and output stalls. The pixel checker predicts and compares.
// ----------------------------------------------------------------------------
module linear_gradient_shader_tb;
  import lgs_pkg::*;

  localparam int unsigned           MAX_STOPS  = 16;
  localparam int unsigned           COORD_BITS = 12;
  localparam logic [COORD_BITS-1:0] COORD_MAX  = '1;
  localparam int                    SETTLE_CYC = 16;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_stall_o;
  logic [0:0]            mode_i;
  logic [COORD_BITS-1:0] x_pos_i;
  logic [COORD_BITS-1:0] y_pos_i;
  logic [3:0]            stop_index_i;
  logic [31:0]           stop_color_i;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  logic [31:0]           pixel_o;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [31:0]           cfg_wdata_i;

  int                    pending;
  int                    mismatch_cnt;
  logic                  req_taken = 1'b0;
  int                    burst_left = 0;

  linear_gradient_shader #(
    .MAX_STOPS  (MAX_STOPS),
    .COORD_BITS (COORD_BITS)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .mode_i       (mode_i),
    .x_pos_i      (x_pos_i),
    .y_pos_i      (y_pos_i),
    .stop_index_i (stop_index_i),
    .stop_color_i (stop_color_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .pixel_o      (pixel_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  lgs_pixel_checker #(
    .MAX_STOPS  (MAX_STOPS),
    .COORD_BITS (COORD_BITS)
  ) u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .req_stall_i    (in_stall_o),
    .mode_i         (mode_i),
    .x_pos_i        (x_pos_i),
    .y_pos_i        (y_pos_i),
    .stop_index_i   (stop_index_i),
    .stop_color_i   (stop_color_i),
    .out_valid_i    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .pixel_i        (pixel_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .pending_o      (pending),
    .mismatch_cnt_o (mismatch_cnt)
  );

  // 100 MHz clock
  always #5 clk_i = ~clk_i;

  // Note whether the request on the bus was taken at this edge
  always @(posedge clk_i) begin
    req_taken <= (in_valid_i === 1'b1) && (in_stall_o === 1'b0);
  end

  // Output backpressure: switch at random among four stall styles
  int stall_style = 0;
  int style_left  = 0;
  int hold_left   = 0;
  logic hold_level = 1'b0;

  always @(negedge clk_i) begin
    if (style_left == 0) begin
      style_left  = $urandom_range(20, 200);
      stall_style = $urandom_range(0, 3);
    end
    style_left--;
    case (stall_style)
      0: out_stall_i <= 1'b0;
      1: out_stall_i <= ($urandom_range(0, 3) == 0);
      2: out_stall_i <= ($urandom_range(0, 3) != 0);
      default: begin
        if (hold_left == 0) begin
          hold_left  = $urandom_range(1, 24);
          hold_level = ~hold_level;
        end
        hold_left--;
        out_stall_i <= hold_level;
      end
    endcase
  end

  function automatic logic [31:0] pick_coef();
    case ($urandom_range(0, 5))
      0:       return 32'h0;
      1:       return $urandom();
      2:       return 32'($urandom_range(0, 8192)) - 32'd4096;
      3:       return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      4:       return 32'($urandom_range(0, 32'h80000)) - 32'h40000;
      default: return 32'($urandom_range(0, 128)) - 32'd64;
    endcase
  endfunction

  function automatic logic [COORD_BITS-1:0] pick_coord();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return COORD_MAX;
      default: return COORD_BITS'($urandom());
    endcase
  endfunction

  function automatic logic [31:0] pick_color();
    case ($urandom_range(0, 5))
      0:       return {8'hFF, 24'($urandom())};
      1:       return {8'h00, 24'($urandom())};
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [4:0] pick_stops();
    case ($urandom_range(0, 9))
      0:       return 5'd2;
      1:       return 5'd16;
      2:       return 5'($urandom_range(0, 31));
      default: return 5'($urandom_range(2, 16));
    endcase
  endfunction

  // Present one request, possibly after a burst gap, and hold it until taken
  task automatic issue_request(input mode_e m, input logic [COORD_BITS-1:0] x,
                               input logic [COORD_BITS-1:0] y, input logic [3:0] slot,
                               input logic [31:0] color);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    burst_left--;
    mode_i       <= m;
    x_pos_i      <= x;
    y_pos_i      <= y;
    stop_index_i <= slot;
    stop_color_i <= color;
    in_valid_i   <= 1'b1;
    do @(negedge clk_i); while (!req_taken);
  endtask

  // Drop valid, wait for every owed pixel, then let loads finish
  task automatic settle();
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (pending != 0) @(negedge clk_i);
    repeat (SETTLE_CYC) @(negedge clk_i);
  endtask

  // Write all five gradient registers back to back
  task automatic program_gradient(input logic [31:0] cx, input logic [31:0] cy,
                                  input logic [31:0] co, input logic [1:0] tm,
                                  input logic [4:0] sc);
    logic [CFG_IDX_W-1:0] regs [5];
    logic [31:0]          vals [5];
    int                   i;
    regs = '{CFG_COEF_X, CFG_COEF_Y, CFG_COEF_OFFSET, CFG_TILE_MODE, CFG_STOP_COUNT};
    vals = '{cx, cy, co, {30'd0, tm}, {27'd0, sc}};
    for (i = 0; i < 5; i++) begin
      cfg_we_i    <= 1'b1;
      cfg_index_i <= regs[i];
      cfg_wdata_i <= vals[i];
      @(negedge clk_i);
    end
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    int          ph;
    int          i;
    logic [31:0] color;
    rst_ni       <= 1'b0;
    in_valid_i   <= 1'b0;
    mode_i       <= MODE_LOAD;
    x_pos_i      <= '0;
    y_pos_i      <= '0;
    stop_index_i <= '0;
    stop_color_i <= '0;
    cfg_we_i     <= 1'b0;
    cfg_index_i  <= CFG_COEF_X;
    cfg_wdata_i  <= '0;
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Fill every table slot before any pixel reads it
    for (i = 0; i < MAX_STOPS; i++) begin
      case (i)
        0:       color = 32'hFFFF_FFFF;
        1:       color = 32'h0000_0000;
        15:      color = 32'h80FF_4020;
        default: color = pick_color();
      endcase
      issue_request(MODE_LOAD, pick_coord(), pick_coord(), i[3:0], color);
    end

    // Reset setup: t is zero everywhere, first stop only
    issue_request(MODE_SHADE, '0, '0, '0, '0);
    issue_request(MODE_SHADE, COORD_MAX, COORD_MAX, '0, '0);
    settle();

    // Exactly 1.0 under clamp: last stop alone
    program_gradient(32'h0, 32'h0, 32'h0001_0000, TILE_CLAMP, 5'd16);
    issue_request(MODE_SHADE, 12'd7, 12'd9, '0, '0);
    settle();

    // Unused tile code behaves as clamp, both ends; stop count saturates high
    program_gradient(32'h0, 32'h7FFF_FFFF, 32'h8000_0000, 2'd3, 5'd31);
    issue_request(MODE_SHADE, '0, '0, '0, '0);
    issue_request(MODE_SHADE, '0, COORD_MAX, '0, '0);
    settle();

    // Repeat with extreme coefficients; stop count saturates low from zero
    program_gradient(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, TILE_REPEAT, 5'd0);
    issue_request(MODE_SHADE, COORD_MAX, COORD_MAX, '0, '0);
    issue_request(MODE_SHADE, '0, COORD_MAX, '0, '0);
    settle();

    // Mirror on both sides of zero; stop count of one saturates to two
    program_gradient(32'h0000_0100, 32'hFFFF_FF00, 32'h0000_8000, TILE_MIRROR, 5'd1);
    issue_request(MODE_SHADE, COORD_MAX, '0, '0, '0);
    issue_request(MODE_SHADE, '0, COORD_MAX, '0, '0);
    settle();

    // Random phases: new setup, then a mix of shades and table reloads
    for (ph = 0; ph < 12; ph++) begin
      program_gradient(pick_coef(), pick_coef(), pick_coef(),
                       2'($urandom_range(0, 3)), pick_stops());
      for (i = 0; i < 42; i++) begin
        if ($urandom_range(0, 4) == 0) begin
          issue_request(MODE_LOAD, pick_coord(), pick_coord(),
                        4'($urandom_range(0, 15)), pick_color());
        end else begin
          issue_request(MODE_SHADE, pick_coord(), pick_coord(),
                        4'($urandom_range(0, 15)), $urandom());
        end
      end
      settle();
    end

    if (mismatch_cnt == 0) begin
      $display("linear_gradient_shader regression: pass");
    end else begin
      $display("linear_gradient_shader regression: fail");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("linear_gradient_shader regression: fail");
    $finish;
  end

endmodule
